@@ src/atilt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the CORDIC arctangent table for the tilt alarm.
// No dependencies.
package atilt_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANG_W        = 15;   // Q2.13 angle width
  localparam int ROT_W        = 33;   // CORDIC vector width
  localparam int PH_W         = 28;   // CORDIC phase accumulator, 24 fraction bits
  localparam int ACC_W        = 32;   // filter accumulator, Q3.29
  localparam int SQ_W         = 60;   // radicand (sum of squares << 28)

  localparam logic [13:0]        THRESH_RST = 14'd6431;
  localparam logic signed [13:0] OFFSET_RST = 14'sd983;
  localparam logic [15:0]        WEIGHT_RST = 16'd6554;

  typedef logic [1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_OFFSET    = 2'd1,
    REG_WEIGHT    = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ANG_IDLE,
    ANG_SQP,
    ANG_SQQ,
    ANG_SQRT,
    ANG_LOAD,
    ANG_ROT,
    ANG_DONE
  } ang_state_e;

  typedef enum logic [3:0] {
    TOP_IDLE,
    TOP_RGO,
    TOP_RWAIT,
    TOP_PGO,
    TOP_PWAIT,
    TOP_FRMUL,
    TOP_FRADD,
    TOP_FPMUL,
    TOP_FPADD,
    TOP_OUT
  } top_state_e;

  // Request to the angle unit: atan2(num, sqrt(p^2 + q^2))
  typedef struct packed {
    logic               start;
    logic signed [15:0] num;
    logic signed [15:0] p;
    logic signed [15:0] q;
  } ang_req_t;

  typedef struct packed {
    logic                    idle;
    logic                    done;
    logic signed [ANG_W-1:0] angle;
  } ang_rsp_t;

  // atan(2^-i) with 24 fraction bits
  function automatic logic [23:0] atan_lut(input logic [4:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/atilt_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample input and the result output.
// Standalone; widths follow the Q2.13 angle format.
interface atilt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atilt_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] roll_now;
  logic signed [14:0] pitch_now;
  logic signed [14:0] roll_smoothed;
  logic signed [14:0] pitch_smoothed;
  logic               tilted;
  logic               alarm_set;

  modport source (output valid, roll_now, pitch_now, roll_smoothed, pitch_smoothed,
                  tilted, alarm_set, input ready);
  modport sink (input valid, roll_now, pitch_now, roll_smoothed, pitch_smoothed,
                tilted, alarm_set, output ready);
endinterface

@@ src/accel_tilt_alarm_unit.sv @@
`timescale 1ns / 1ps
// Top level of the accelerometer tilt alarm: sequencer, low-pass filters, alarm latch.
// Depends on atilt_pkg, atilt_if and atilt_angle.
//
// Usage:
//   sample_i carries one raw X/Y/Z word; it is taken when valid and ready are high.
//   result_o returns one word per sample: instantaneous roll and pitch (pitch minus
//   offset, saturated), the filtered angles, the tilt flag and the sticky alarm.
//   cfg_we_i/cfg_addr_i/cfg_wdata_i write threshold (0), pitch offset (1) and
//   filter weight (2); other indexes are dropped. Write only while idle.
// Sequence:
//   Each angle runs through the single angle unit, which squares p and q in turn,
//   computes a 30-bit square root one bit per cycle and runs CordicSteps CORDIC
//   iterations; the iterations are skipped when the numerator is zero. The two
//   filters then share one 17x33 multiplier, each in a multiply and an add state.
//   sample_i.ready is high only while the sequencer is idle.
// Reset: filters and alarm clear, registers return to 0.785 / 0.12 / 0.1.
// Stall: the result sits in an output register; the next sample may be taken
//   and processed, and its result waits until the held word is taken.
module accel_tilt_alarm_unit #(
  parameter int CordicSteps = atilt_pkg::CORDIC_STEPS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  atilt_in_if.sink            sample_i,
  atilt_out_if.source         result_o,
  input  logic                cfg_we_i,
  input  atilt_pkg::cfg_idx_t cfg_addr_i,
  input  logic [15:0]         cfg_wdata_i
);
  import atilt_pkg::*;

  top_state_e state_q, state_d;

  // configuration
  logic [13:0]        thresh_q;
  logic signed [13:0] offset_q;
  logic [15:0]        weight_q;

  // sample and angles
  logic signed [15:0]       x_q, y_q, z_q;
  logic signed [ANG_W-1:0]  roll_q, pitch_q;

  // filter state
  logic signed [ACC_W-1:0]  roll_acc_q, pitch_acc_q;
  logic                     alarm_q;
  logic signed [49:0]       prod_q;

  // output register
  logic                     out_valid_q;
  logic signed [ANG_W-1:0]  out_roll_q, out_pitch_q, out_rsm_q, out_psm_q;
  logic                     out_tilt_q, out_alarm_q;

  ang_req_t ang_req;
  ang_rsp_t ang_rsp;

  logic                     in_fire, out_fire, out_free;
  logic signed [15:0]       pitch_diff;
  logic signed [ANG_W-1:0]  pitch_sat;
  logic signed [ANG_W-1:0]  filt_angle;
  logic signed [ACC_W-1:0]  filt_acc;
  logic signed [32:0]       filt_diff;
  logic signed [32:0]       filt_sum;
  logic signed [32:0]       lim, roll_ext, pitch_ext;
  logic                     tilt;
  logic signed [ANG_W-1:0]  roll_rnd, pitch_rnd;

  atilt_angle #(.CordicSteps(CordicSteps)) u_angle (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ang_req),
    .rsp_o (ang_rsp)
  );

  assign in_fire  = sample_i.valid && sample_i.ready;
  assign out_fire = result_o.valid && result_o.ready;
  assign out_free = !out_valid_q || result_o.ready;

  // roll first: atan2(y, |x,z|), then pitch: atan2(x, |y,z|)
  always_comb begin
    ang_req.start = (state_q == TOP_RGO) || (state_q == TOP_PGO);
    ang_req.num   = (state_q == TOP_RGO) ? y_q : x_q;
    ang_req.p     = (state_q == TOP_RGO) ? x_q : y_q;
    ang_req.q     = z_q;
  end

  // pitch minus offset, clamped to 15 bits
  assign pitch_diff = 16'(ang_rsp.angle) - 16'(offset_q);
  always_comb begin
    if (pitch_diff[15] != pitch_diff[14]) begin
      pitch_sat = pitch_diff[15] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
    end else begin
      pitch_sat = pitch_diff[14:0];
    end
  end

  // shared filter datapath: acc += floor(w * (angle<<16 - acc) / 2^16)
  assign filt_angle = (state_q == TOP_FPMUL || state_q == TOP_FPADD) ? pitch_q : roll_q;
  assign filt_acc   = (state_q == TOP_FPMUL || state_q == TOP_FPADD) ? pitch_acc_q : roll_acc_q;
  assign filt_diff  = 33'($signed({filt_angle, 16'd0})) - 33'(filt_acc);
  assign filt_sum   = 33'(filt_acc) + 33'(prod_q >>> 16);

  // tilt compare on the full-precision accumulators
  assign lim       = $signed({3'd0, thresh_q, 16'd0});
  assign roll_ext  = 33'(roll_acc_q);
  assign pitch_ext = 33'(pitch_acc_q);
  assign tilt = (roll_ext > lim) || (roll_ext < -lim) ||
                (pitch_ext > lim) || (pitch_ext < -lim);

  function automatic logic signed [ANG_W-1:0] acc_round(input logic signed [ACC_W-1:0] v);
    logic [ACC_W:0] m;
    logic [ACC_W:0] r;
    m = v[ACC_W-1] ? (ACC_W+1)'(-33'(v)) : (ACC_W+1)'(v);
    r = (m + (ACC_W+1)'(32768)) >> 16;
    return v[ACC_W-1] ? ANG_W'(-r) : ANG_W'(r);
  endfunction

  assign roll_rnd  = acc_round(roll_acc_q);
  assign pitch_rnd = acc_round(pitch_acc_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      TOP_IDLE:  if (in_fire) state_d = TOP_RGO;
      TOP_RGO:   state_d = TOP_RWAIT;
      TOP_RWAIT: if (ang_rsp.done) state_d = TOP_PGO;
      TOP_PGO:   state_d = TOP_PWAIT;
      TOP_PWAIT: if (ang_rsp.done) state_d = TOP_FRMUL;
      TOP_FRMUL: state_d = TOP_FRADD;
      TOP_FRADD: state_d = TOP_FPMUL;
      TOP_FPMUL: state_d = TOP_FPADD;
      TOP_FPADD: state_d = TOP_OUT;
      TOP_OUT:   if (out_free) state_d = TOP_IDLE;
      default:   state_d = TOP_IDLE;
    endcase
  end

  always_comb begin
    sample_i.ready = (state_q == TOP_IDLE);
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.roll_now       = out_roll_q;
  assign result_o.pitch_now      = out_pitch_q;
  assign result_o.roll_smoothed  = out_rsm_q;
  assign result_o.pitch_smoothed = out_psm_q;
  assign result_o.tilted         = out_tilt_q;
  assign result_o.alarm_set      = out_alarm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TOP_IDLE;
      thresh_q    <= THRESH_RST;
      offset_q    <= OFFSET_RST;
      weight_q    <= WEIGHT_RST;
      roll_acc_q  <= '0;
      pitch_acc_q <= '0;
      alarm_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_THRESHOLD: thresh_q <= cfg_wdata_i[13:0];
          REG_OFFSET:    offset_q <= cfg_wdata_i[13:0];
          REG_WEIGHT:    weight_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == TOP_FRADD) roll_acc_q  <= filt_sum[ACC_W-1:0];
      if (state_q == TOP_FPADD) pitch_acc_q <= filt_sum[ACC_W-1:0];
      if (state_q == TOP_OUT && out_free) begin
        out_valid_q <= 1'b1;
        if (tilt) alarm_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= sample_i.accel_x;
      y_q <= sample_i.accel_y;
      z_q <= sample_i.accel_z;
    end
    if (state_q == TOP_RWAIT && ang_rsp.done) roll_q  <= ang_rsp.angle;
    if (state_q == TOP_PWAIT && ang_rsp.done) pitch_q <= pitch_sat;
    if (state_q == TOP_FRMUL || state_q == TOP_FPMUL) begin
      prod_q <= $signed({1'b0, weight_q}) * filt_diff;
    end
    if (state_q == TOP_OUT && out_free) begin
      out_roll_q  <= roll_q;
      out_pitch_q <= pitch_q;
      out_rsm_q   <= roll_rnd;
      out_psm_q   <= pitch_rnd;
      out_tilt_q  <= tilt;
      out_alarm_q <= alarm_q || tilt;
    end
  end

  // the alarm latch only ever sets
  a_alarm_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(alarm_q))
    else $error("alarm latch cleared without reset");

  // a flagged tilt always reports the alarm
  a_tilt_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_tilt_q) |-> out_alarm_q)
    else $error("tilt reported without alarm");

  // angle unit is only started when free
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ang_req.start |-> ang_rsp.idle)
    else $error("angle unit started while busy");

  // a held result is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == TOP_OUT && out_valid_q && !result_o.ready) |=> (state_q == TOP_OUT))
    else $error("result overwritten while stalled");

endmodule

@@ src/atilt_angle.sv @@
`timescale 1ns / 1ps
// Iterative angle unit: squares, bit-serial square root, vectoring CORDIC.
// Depends on atilt_pkg.
module atilt_angle #(
  parameter int CordicSteps = atilt_pkg::CORDIC_STEPS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  atilt_pkg::ang_req_t req_i,
  output atilt_pkg::ang_rsp_t rsp_o
);
  import atilt_pkg::*;

  localparam int IterW = $clog2(CordicSteps);

  ang_state_e state_q, state_d;

  logic signed [15:0]       p_q, q_q, num_q;
  logic [31:0]              ss_q;
  logic [SQ_W-1:0]          n_q, res_q, bit_q;
  logic signed [ROT_W-1:0]  a_q, b_q;
  logic signed [PH_W-1:0]   ph_q;
  logic [IterW-1:0]         iter_q;

  logic signed [15:0]       mul_op;
  logic signed [31:0]       sq;
  logic [31:0]              ss_sum;
  logic [SQ_W-1:0]          trial;
  logic signed [ROT_W-1:0]  da, db;
  logic signed [PH_W-1:0]   step;
  logic                     last_iter;
  logic                     neg;
  logic [PH_W-1:0]          mag;
  logic [PH_W-1:0]          rmag;
  logic signed [PH_W-1:0]   rounded;

  // shared squarer
  assign mul_op    = (state_q == ANG_SQP) ? p_q : q_q;
  assign sq        = mul_op * mul_op;
  assign ss_sum    = ss_q + sq;
  assign trial     = res_q + bit_q;
  assign da        = b_q >>> iter_q;
  assign db        = a_q >>> iter_q;
  assign step      = PH_W'(atan_lut(5'(iter_q)));
  assign last_iter = (iter_q == IterW'(CordicSteps - 1));

  // round half away from zero, 24 -> 13 fraction bits
  assign neg     = ph_q[PH_W-1];
  assign mag     = neg ? PH_W'(-ph_q) : PH_W'(ph_q);
  assign rmag    = (mag + PH_W'(1024)) >> 11;
  assign rounded = neg ? -$signed(rmag) : $signed(rmag);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ANG_IDLE: if (req_i.start) state_d = ANG_SQP;
      ANG_SQP:  state_d = ANG_SQQ;
      ANG_SQQ:  state_d = ANG_SQRT;
      ANG_SQRT: if (bit_q[0]) state_d = ANG_LOAD;
      ANG_LOAD: state_d = (num_q == 16'sd0) ? ANG_DONE : ANG_ROT;
      ANG_ROT:  if (last_iter) state_d = ANG_DONE;
      ANG_DONE: state_d = ANG_IDLE;
      default:  state_d = ANG_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.idle  = (state_q == ANG_IDLE);
    rsp_o.done  = (state_q == ANG_DONE);
    rsp_o.angle = ANG_W'(rounded);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ANG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ANG_IDLE: begin
        p_q   <= req_i.p;
        q_q   <= req_i.q;
        num_q <= req_i.num;
      end
      ANG_SQP: ss_q <= 32'(sq);
      ANG_SQQ: begin
        n_q   <= {ss_sum, 28'd0};
        res_q <= '0;
        bit_q <= SQ_W'(1) << (SQ_W - 2);
      end
      ANG_SQRT: begin
        if (n_q >= trial) begin
          n_q   <= n_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ANG_LOAD: begin
        a_q    <= ROT_W'({1'b0, res_q[29:0]});
        b_q    <= ROT_W'($signed({num_q, 14'd0}));
        ph_q   <= '0;
        iter_q <= '0;
      end
      ANG_ROT: begin
        if (!b_q[ROT_W-1]) begin
          a_q  <= a_q + da;
          b_q  <= b_q - db;
          ph_q <= ph_q + step;
        end else begin
          a_q  <= a_q - da;
          b_q  <= b_q + db;
          ph_q <= ph_q - step;
        end
        iter_q <= iter_q + 1'b1;
      end
      default: ;
    endcase
  end

endmodule
